// ===== rtl/sts_pkg.sv =====
package sts_pkg;

    // item kinds carried on s_tuser
    localparam logic [1:0] KIND_APPEND = 2'd0;
    localparam logic [1:0] KIND_QUERY  = 2'd1;
    localparam logic [1:0] KIND_CLEAR  = 2'd2;

    localparam int KIND_W   = 2;
    localparam int IN_W     = 32;
    localparam int OUT_IDX_W = 11;
    localparam int OUT_W    = 24;

    localparam int DEF_TABLE_DEPTH = 1024;
    localparam int DEF_VALUE_WIDTH = 32;

    localparam logic [OUT_IDX_W-1:0] IDX_NONE = '1;

    // one finished result, before packing onto m_tdata
    typedef struct packed {
        logic                 overflow;
        logic [OUT_IDX_W-1:0] last_index;
        logic [OUT_IDX_W-1:0] first_index;
        logic                 found;
    } result_t;

endpackage

// ===== rtl/sts_table_ram.sv =====
module sts_table_ram #(
    parameter int DEPTH = sts_pkg::DEF_TABLE_DEPTH,
    parameter int WIDTH = sts_pkg::DEF_VALUE_WIDTH,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/sorted_table_equal_range_search_top.sv =====
// Sorted table with equal-range search. Values arrive on s_tdata with
// s_tuser giving the kind: append, query or clear. Appends must come in
// non-decreasing signed order; an append into a full table is dropped and
// answered with a result that has overflow set. A query is answered with
// the first and last index of the entries equal to the key, or all ones
// (-1) for both when the key is absent. A stored append, a clear or an
// ignored kind is handled in the idle state; a dropped append or a query
// on an empty table passes through the done state. A query takes a
// lower-bound binary search, a check read, and an upper-bound binary
// search over the table memory, one memory read per step; a missing key
// stops after the check read or earlier. A result waits in the done state
// until the result register is free. The table memory has a single read
// port. One item is worked on at a time; s_tready is high only while the
// block is idle.
module sorted_table_equal_range_search_top #(
    parameter int TABLE_DEPTH = sts_pkg::DEF_TABLE_DEPTH,
    parameter int VALUE_WIDTH = sts_pkg::DEF_VALUE_WIDTH
) (
    input  logic                        aclk,
    input  logic                        aresetn,

    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [sts_pkg::IN_W-1:0]    s_tdata,   // [31:0] value
    input  logic [sts_pkg::KIND_W-1:0]  s_tuser,   // [1:0] kind

    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [sts_pkg::OUT_W-1:0]   m_tdata    // [0] found, [11:1] first_index,
                                                   // [22:12] last_index, [23] overflow
);

    localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_LB   = 3'd1;
    localparam logic [2:0] ST_CHK  = 3'd2;
    localparam logic [2:0] ST_UB   = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    logic [2:0]                    state_reg, state_next;
    logic [CNT_W-1:0]              count_reg, count_next;
    logic [CNT_W-1:0]              lo_reg, lo_next;
    logic [CNT_W-1:0]              hi_reg, hi_next;
    logic [CNT_W-1:0]              mid_reg, mid_next;
    logic [CNT_W-1:0]              lb_reg, lb_next;
    logic signed [VALUE_WIDTH-1:0] key_reg, key_next;
    sts_pkg::result_t              res_reg, res_next;
    logic                          m_valid_reg, m_valid_next;
    sts_pkg::result_t              out_reg, out_next;

    logic                          in_fire;
    logic [63:0]                   value_ext;
    logic signed [VALUE_WIDTH-1:0] key_in;
    logic                          wr_en;
    logic [ADDR_W-1:0]             rd_addr;
    logic [CNT_W-1:0]              rd_idx;
    logic [VALUE_WIDTH-1:0]        rd_data;
    logic signed [VALUE_WIDTH-1:0] entry;
    logic                          go_right;
    logic [CNT_W-1:0]              step_lo, step_hi, step_mid;
    logic [CNT_W-1:0]              mid_first;
    logic [CNT_W-1:0]              last_pos;
    logic [31:0]                   lb_wide, last_wide;

    assign in_fire   = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign value_ext = {{32{s_tdata[sts_pkg::IN_W-1]}}, s_tdata};
    assign key_in    = value_ext[VALUE_WIDTH-1:0];
    assign entry     = rd_data;
    assign mid_first = count_reg >> 1;

    assign wr_en = in_fire && (s_tuser == sts_pkg::KIND_APPEND) && (count_reg != DEPTH_CNT);

    sts_table_ram #(
        .DEPTH (TABLE_DEPTH),
        .WIDTH (VALUE_WIDTH)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[ADDR_W-1:0]),
        .wr_data (key_in),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // one bisection step on the entry read at mid_reg
    always_comb begin
        if (state_reg == ST_UB) begin
            go_right = (entry <= key_reg);
        end else begin
            go_right = (entry < key_reg);
        end
        step_lo  = go_right ? (mid_reg + CNT_W'(1)) : lo_reg;
        step_hi  = go_right ? hi_reg : mid_reg;
        step_mid = step_lo + ((step_hi - step_lo) >> 1);
    end

    assign last_pos  = (step_lo <= lb_reg) ? lb_reg : (step_lo - CNT_W'(1));
    assign lb_wide   = 32'(lb_reg);
    assign last_wide = 32'(last_pos);
    assign rd_addr   = rd_idx[ADDR_W-1:0];

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        mid_next     = mid_reg;
        lb_next      = lb_reg;
        key_next     = key_reg;
        res_next     = res_reg;
        rd_idx       = mid_reg;
        m_valid_next = m_valid_reg;
        out_next     = out_reg;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                rd_idx = mid_first;
                if (in_fire) begin
                    unique case (s_tuser)
                        sts_pkg::KIND_APPEND: begin
                            if (count_reg != DEPTH_CNT) begin
                                count_next = count_reg + CNT_W'(1);
                            end else begin
                                res_next = '{overflow: 1'b1, last_index: sts_pkg::IDX_NONE,
                                             first_index: sts_pkg::IDX_NONE, found: 1'b0};
                                state_next = ST_DONE;
                            end
                        end
                        sts_pkg::KIND_QUERY: begin
                            key_next = key_in;
                            res_next = '{overflow: 1'b0, last_index: sts_pkg::IDX_NONE,
                                         first_index: sts_pkg::IDX_NONE, found: 1'b0};
                            if (count_reg == '0) begin
                                state_next = ST_DONE;
                            end else begin
                                lo_next    = '0;
                                hi_next    = count_reg;
                                mid_next   = mid_first;
                                state_next = ST_LB;
                            end
                        end
                        sts_pkg::KIND_CLEAR: begin
                            count_next = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_LB: begin
                lo_next = step_lo;
                hi_next = step_hi;
                if (step_lo < step_hi) begin
                    mid_next = step_mid;
                    rd_idx   = step_mid;
                end else begin
                    lb_next = step_lo;
                    if (step_lo >= count_reg) begin
                        state_next = ST_DONE;
                    end else begin
                        rd_idx     = step_lo;
                        state_next = ST_CHK;
                    end
                end
            end
            ST_CHK: begin
                // restart the upper-bound search over the whole table
                rd_idx = mid_first;
                if (entry != key_reg) begin
                    state_next = ST_DONE;
                end else begin
                    lo_next    = '0;
                    hi_next    = count_reg;
                    mid_next   = mid_first;
                    state_next = ST_UB;
                end
            end
            ST_UB: begin
                lo_next = step_lo;
                hi_next = step_hi;
                if (step_lo < step_hi) begin
                    mid_next = step_mid;
                    rd_idx   = step_mid;
                end else begin
                    res_next = '{overflow: 1'b0,
                                 last_index: last_wide[sts_pkg::OUT_IDX_W-1:0],
                                 first_index: lb_wide[sts_pkg::OUT_IDX_W-1:0],
                                 found: 1'b1};
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                // hold until the result register is free
                if (!m_valid_reg || m_tready) begin
                    out_next     = res_reg;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
        mid_reg <= mid_next;
        lb_reg  <= lb_next;
        key_reg <= key_next;
        res_reg <= res_next;
        out_reg <= out_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = out_reg;

endmodule

// ===== tb/sorted_table_equal_range_search_top_tb.sv =====
module sorted_table_equal_range_search_top_tb;

    import sts_pkg::*;

    localparam int                 TABLE_DEPTH  = DEF_TABLE_DEPTH;
    localparam logic [KIND_W-1:0]  KIND_IGNORED = 2'd3;
    localparam logic signed [31:0] VALUE_MIN    = 32'sh8000_0000;
    localparam logic signed [31:0] VALUE_MAX    = 32'sh7FFF_FFFF;
    localparam int                 DRAIN_CYCLES = 40;

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [IN_W-1:0]     s_tdata;
    logic [KIND_W-1:0]   s_tuser;
    logic                m_tvalid;
    logic                m_tready;
    logic [OUT_W-1:0]    m_tdata;

    // mirror of the block state
    logic signed [31:0]  table_mirror [TABLE_DEPTH];
    int                  mirror_count;
    result_t             expected_results [$];

    int                  send_idle_pct;
    int                  recv_idle_pct;
    int                  hold_cycles_req;
    int                  items_sent;
    int                  results_seen;
    int                  error_count;

    sorted_table_equal_range_search_top #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .VALUE_WIDTH (DEF_VALUE_WIDTH)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial aclk = 1'b0;
    always #10 aclk = ~aclk;

    initial begin
        #(20 * 600000);
        $display("sorted_table_equal_range_search_top test failed");
        $finish;
    end

    // first position whose entry is >= key, or > key when strict
    function automatic int find_bound(input logic signed [31:0] key, input bit strict);
        int lo;
        int hi;
        int mid;
        logic signed [31:0] entry;
        lo = 0;
        hi = mirror_count;
        while (lo < hi) begin
            mid = lo + ((hi - lo) >> 1);
            entry = table_mirror[mid];
            if (entry < key || (strict && entry == key))
                lo = mid + 1;
            else
                hi = mid;
        end
        return lo;
    endfunction

    function automatic void predict_item(input logic [KIND_W-1:0] kind,
                                         input logic signed [31:0] value);
        result_t r;
        int lb;
        int ub;
        r.found       = 1'b0;
        r.first_index = IDX_NONE;
        r.last_index  = IDX_NONE;
        r.overflow    = 1'b0;
        case (kind)
            KIND_APPEND: begin
                if (mirror_count < TABLE_DEPTH) begin
                    table_mirror[mirror_count] = value;
                    mirror_count++;
                end else begin
                    r.overflow = 1'b1;
                    expected_results.push_back(r);
                end
            end
            KIND_CLEAR: begin
                mirror_count = 0;
            end
            KIND_QUERY: begin
                lb = find_bound(value, 1'b0);
                if (lb < mirror_count && table_mirror[lb] == value) begin
                    ub = find_bound(value, 1'b1);
                    if (ub == 0 || ub - 1 < lb)
                        ub = lb + 1;
                    r.found       = 1'b1;
                    r.first_index = OUT_IDX_W'(lb);
                    r.last_index  = OUT_IDX_W'(ub - 1);
                end
                expected_results.push_back(r);
            end
            default: begin
            end
        endcase
    endfunction

    // leaves s_tvalid high after the transaction; only idle_sender or an idle gap lowers it
    task automatic send_item(input logic [KIND_W-1:0] kind, input logic [31:0] value);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tuser  <= kind;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        predict_item(kind, value);
        if (kind != KIND_IGNORED)
            items_sent++;
    endtask

    task automatic idle_sender();
        s_tvalid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic wait_results_drained();
        idle_sender();
        while (expected_results.size() != 0)
            @(posedge aclk);
    endtask

    task automatic load_sorted(input int n);
        longint cur;
        case ($urandom_range(0, 3))
            0:       cur = longint'(VALUE_MIN) + $urandom_range(0, 8);
            1:       cur = longint'(VALUE_MAX) - $urandom_range(0, 64);
            default: cur = longint'(int'($urandom()));
        endcase
        for (int i = 0; i < n; i++) begin
            send_item(KIND_APPEND, 32'(cur));
            case ($urandom_range(0, 9))
                0, 1, 2:       ;  // duplicate
                3, 4, 5, 6, 7: cur = cur + $urandom_range(1, 3);
                default:       cur = cur + $urandom_range(1, 1 << 24);
            endcase
            if (cur > longint'(VALUE_MAX))
                cur = longint'(VALUE_MAX);
        end
    endtask

    function automatic logic [31:0] pick_key();
        logic signed [31:0] base;
        base = (mirror_count == 0) ? 32'($urandom())
                                   : table_mirror[$urandom_range(0, mirror_count - 1)];
        case ($urandom_range(0, 7))
            0, 1, 2, 3: return base;
            4:          return base + 1;
            5:          return base - 1;
            6:          return $urandom();
            default:    return $urandom_range(0, 1) ? VALUE_MIN : VALUE_MAX;
        endcase
    endfunction

    task automatic test_empty_table();
        send_item(KIND_QUERY, 32'd0);
        send_item(KIND_IGNORED, $urandom());
        send_item(KIND_CLEAR, 32'hFFFF_FFFF);
    endtask

    task automatic test_extreme_values();
        send_item(KIND_APPEND, VALUE_MIN);
        send_item(KIND_APPEND, VALUE_MIN);
        send_item(KIND_APPEND, 32'd0);
        send_item(KIND_APPEND, 32'd0);
        send_item(KIND_APPEND, VALUE_MAX);
        send_item(KIND_QUERY, VALUE_MIN);
        send_item(KIND_QUERY, 32'd0);
        send_item(KIND_QUERY, VALUE_MAX);
        send_item(KIND_QUERY, 32'hFFFF_FFFF);
    endtask

    task automatic test_unsorted_table();
        send_item(KIND_CLEAR, 32'd0);
        send_item(KIND_APPEND, 32'd9);
        send_item(KIND_APPEND, 32'd2);
        send_item(KIND_APPEND, 32'd5);
        send_item(KIND_APPEND, 32'd2);
        send_item(KIND_QUERY, 32'd2);
        send_item(KIND_QUERY, 32'd9);
        send_item(KIND_QUERY, 32'd5);
    endtask

    task automatic test_clear_then_query();
        send_item(KIND_CLEAR, 32'd0);
        send_item(KIND_QUERY, 32'd2);
    endtask

    task automatic test_random_tables(input int target);
        int n;
        while (items_sent < target) begin
            send_item(KIND_CLEAR, $urandom());
            n = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 24);
            load_sorted(n);
            repeat ($urandom_range(4, 12)) begin
                case ($urandom_range(0, 19))
                    0:       send_item(KIND_IGNORED, $urandom());
                    1:       send_item(KIND_APPEND, $urandom());  // may break the order
                    default: send_item(KIND_QUERY, pick_key());
                endcase
            end
        end
    endtask

    task automatic test_output_backpressure();
        send_item(KIND_CLEAR, 32'd0);
        load_sorted(8);
        hold_cycles_req = 400;
        repeat (12)
            send_item(KIND_QUERY, pick_key());
        wait_results_drained();
    endtask

    task automatic test_full_table();
        send_item(KIND_CLEAR, 32'd0);
        load_sorted(TABLE_DEPTH);
        repeat (4)
            send_item(KIND_APPEND, $urandom());
        send_item(KIND_QUERY, table_mirror[0]);
        send_item(KIND_QUERY, table_mirror[TABLE_DEPTH - 1]);
        repeat (16)
            send_item(KIND_QUERY, pick_key());
    endtask

    // receiver; a hold-off request in hold_cycles_req holds m_tready low for the hold
    initial begin
        int held;
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_cycles_req > 0) begin
                held = hold_cycles_req;
                hold_cycles_req = 0;
                m_tready <= 1'b0;
                repeat (held)
                    @(posedge aclk);
            end
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = result_t'(m_tdata);
            results_seen++;
            if (expected_results.size() == 0) begin
                $error("unexpected result transaction m_tdata=%h", m_tdata);
                error_count++;
            end else begin
                want = expected_results.pop_front();
                if (got.found !== want.found) begin
                    $error("found: expected %0d actual %0d", want.found, got.found);
                    error_count++;
                end
                if (got.first_index !== want.first_index) begin
                    $error("first_index: expected %0d actual %0d",
                           $signed(want.first_index), $signed(got.first_index));
                    error_count++;
                end
                if (got.last_index !== want.last_index) begin
                    $error("last_index: expected %0d actual %0d",
                           $signed(want.last_index), $signed(got.last_index));
                    error_count++;
                end
                if (got.overflow !== want.overflow) begin
                    $error("overflow: expected %0d actual %0d", want.overflow, got.overflow);
                    error_count++;
                end
            end
        end
    end

    initial begin
        aresetn         = 1'b0;
        s_tvalid        = 1'b0;
        s_tdata         = '0;
        s_tuser         = '0;
        mirror_count    = 0;
        hold_cycles_req = 0;
        items_sent      = 0;
        results_seen    = 0;
        error_count     = 0;
        send_idle_pct   = 22;
        recv_idle_pct   = 75;
        repeat (3)
            @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_empty_table();
        test_extreme_values();
        test_unsorted_table();
        test_clear_then_query();
        test_random_tables(350);

        send_idle_pct = 75;
        recv_idle_pct = 22;
        test_random_tables(650);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_output_backpressure();
        test_full_table();

        wait_results_drained();
        repeat (DRAIN_CYCLES)
            @(posedge aclk);
        if (expected_results.size() != 0) begin
            $error("%0d expected results never arrived", expected_results.size());
            error_count++;
        end

        $display("Sent %0d appends, clears and queries and checked %0d results,", items_sent,
                 results_seen);
        $display("over small and full tables, out-of-order loads and a long output stall.");
        if (error_count == 0)
            $display("sorted_table_equal_range_search_top test passed");
        else
            $display("sorted_table_equal_range_search_top test failed");
        $finish;
    end

endmodule
